/* design/phase_cut_dimmer_8ch_unit_assert.svh */
// Assertion macros for the phase-cut dimmer.
// Included by the modules that check their own logic; needs no package.
`ifndef PHASE_CUT_DIMMER_8CH_UNIT_ASSERT_SVH
`define PHASE_CUT_DIMMER_8CH_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dimmer same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dimmer next-cycle check failed");

`endif

/* design/pcd_pkg.sv */
// Shared types and constants of the phase-cut dimmer.
// Used by pcd_core and phase_cut_dimmer_8ch_unit; depends on nothing.
package pcd_pkg;

  localparam int LEVEL_W = 8;
  localparam int LAMP_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int CODE_W  = 2;

  // Event kinds
  localparam logic [FUNC_W-1:0] EV_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] EV_ZERO = 2'd1;
  localparam logic [FUNC_W-1:0] EV_BYTE = 2'd2;

  // Second-byte commands
  localparam logic [LEVEL_W-1:0] CMD_SET_ALL  = 8'd0;
  localparam logic [LEVEL_W-1:0] CMD_COMMENCE = 8'd9;

  // Reply codes
  localparam logic [CODE_W-1:0] REPLY_ERROR = 2'd0;
  localparam logic [CODE_W-1:0] REPLY_ACK1  = 2'd1;
  localparam logic [CODE_W-1:0] REPLY_ACK2  = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_OFF = 8'd255;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] rx_byte;
  } pcd_item_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic              reply_valid;
    logic [CODE_W-1:0] reply_code;
  } pcd_result_t;

endpackage

/* design/pcd_core.sv */
// Dimmer state and next-state logic: phase counter, levels, lamps, byte parser.
// Depends on pcd_pkg and phase_cut_dimmer_8ch_unit_assert.svh.
module pcd_core
  import pcd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  pcd_item_t   item,
  output pcd_result_t res
);

  logic [LEVEL_W-1:0]  tick_count_r, tick_count_nxt;
  logic [LEVEL_W-1:0]  active_r  [CHANNELS];
  logic [LEVEL_W-1:0]  active_nxt[CHANNELS];
  logic [LEVEL_W-1:0]  pending_r  [CHANNELS];
  logic [LEVEL_W-1:0]  pending_nxt[CHANNELS];
  logic [CHANNELS-1:0] lamp_r, lamp_nxt;
  logic                phase_r, phase_nxt;
  logic [LEVEL_W-1:0]  cmd_r;
  logic [CHANNELS-1:0] match;
  logic                is_byte, second_byte, cmd_ok;
  logic                do_set_all, do_commence;
  logic                tick_fire, zero_fire;

  // Advance or clear the phase counter
  always_comb begin
    case (item.func)
      EV_TICK: tick_count_nxt = tick_count_r + 8'd1;
      EV_ZERO: tick_count_nxt = '0;
      default: tick_count_nxt = tick_count_r;
    endcase
  end

  // Compare every channel against the new count
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      match[i] = (active_r[i] == tick_count_nxt);
    end
  end

  // Latch matching lamps on a tick, restart them on a zero crossing
  always_comb begin
    case (item.func)
      EV_TICK: lamp_nxt = lamp_r | match;
      EV_ZERO: lamp_nxt = match;
      default: lamp_nxt = lamp_r;
    endcase
  end

  // Decode the second byte of a command pair
  assign is_byte     = (item.func == EV_BYTE);
  assign second_byte = is_byte && phase_r;
  assign do_set_all  = second_byte && (cmd_r == CMD_SET_ALL);
  assign do_commence = second_byte && (cmd_r == CMD_COMMENCE);
  assign cmd_ok      = (cmd_r == CMD_SET_ALL) || (cmd_r == CMD_COMMENCE) ||
                       ((cmd_r != CMD_SET_ALL) && (cmd_r <= LEVEL_W'(CHANNELS)));
  assign phase_nxt   = is_byte ? !phase_r : phase_r;

  // Update pending and active levels per channel
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      pending_nxt[i] = pending_r[i];
      active_nxt[i]  = active_r[i];
      if (do_set_all || (second_byte && (cmd_r == LEVEL_W'(i + 1)))) begin
        pending_nxt[i] = item.rx_byte;
      end
      if (do_commence) begin
        active_nxt[i] = pending_r[i];
      end
    end
  end

  // Form the result of this item
  always_comb begin
    res.lamps       = LAMP_W'(lamp_nxt);
    res.reply_valid = is_byte;
    if (!is_byte) begin
      res.reply_code = REPLY_ERROR;
    end else if (!phase_r) begin
      res.reply_code = REPLY_ACK1;
    end else if (cmd_ok) begin
      res.reply_code = REPLY_ACK2;
    end else begin
      res.reply_code = REPLY_ERROR;
    end
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      lamp_r       <= '0;
      phase_r      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        active_r[i]  <= LEVEL_OFF;
        pending_r[i] <= LEVEL_OFF;
      end
    end else if (fire) begin
      tick_count_r <= tick_count_nxt;
      lamp_r       <= lamp_nxt;
      phase_r      <= phase_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        active_r[i]  <= active_nxt[i];
        pending_r[i] <= pending_nxt[i];
      end
    end
  end

  // Hold the command byte of the first byte of a pair
  always_ff @(posedge clk) begin
    if (fire && is_byte && !phase_r) begin
      cmd_r <= item.rx_byte;
    end
  end

  // Committed ticks and zero crossings
  assign tick_fire = fire && (item.func == EV_TICK);
  assign zero_fire = fire && (item.func == EV_ZERO);

`include "phase_cut_dimmer_8ch_unit_assert.svh"

  `PCD_ASSERT_NEXT(a_tick_adv, clk, rst_n, tick_fire, tick_count_r == $past(tick_count_r) + 8'd1)
  `PCD_ASSERT_NEXT(a_zero_clr, clk, rst_n, zero_fire, tick_count_r == '0)
  `PCD_ASSERT_SAME(a_first_ack, clk, rst_n, is_byte && !phase_r, res.reply_code == REPLY_ACK1)
  `PCD_ASSERT_NEXT(a_idle_hold, clk, rst_n, !fire, $stable({lamp_r, phase_r, tick_count_r}))

endmodule

/* design/phase_cut_dimmer_8ch_unit.sv */
// Eight-channel phase-cut dimmer top level: input register, core, result register.
// Depends on pcd_pkg and pcd_core.
//
// Use: each input item (in_func, in_rx_byte) is a timer tick, a mains zero
// crossing or a received serial byte. Every item gives exactly one result:
// out_lamps (gate drive after the item), out_reply_valid and out_reply_code.
// Both channels move an item on a clock edge where valid is high and stall
// is low.
// Path: an accepted item waits in the input register; its result is loaded
// into the result register when that register is empty or being taken.
// Throughput: one item per cycle while out_stall stays low; the core's compares
// and level updates sit between the input register and the result register.
// Stall: while out_stall holds a result, the input register still takes one
// more item; in_stall rises only when both registers are full and the
// result cannot leave.
// Reset (rst_n low, synchronous): both registers empty, counter and lamps
// clear, all levels 255, byte parser waits for a command byte.
module phase_cut_dimmer_8ch_unit
  import pcd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [LEVEL_W-1:0] in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LAMP_W-1:0]  out_lamps,
  output logic               out_reply_valid,
  output logic [CODE_W-1:0]  out_reply_code
);

  logic        in_vld_r;
  pcd_item_t   in_item_r;
  logic        out_vld_r;
  pcd_result_t out_res_r;
  pcd_result_t core_res;
  logic        advance, fire, accept;

  // Result register can load when empty or being taken
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.func    <= in_func;
      in_item_r.rx_byte <= in_rx_byte;
    end
  end

  pcd_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .res   (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_lamps       = out_res_r.lamps;
  assign out_reply_valid = out_res_r.reply_valid;
  assign out_reply_code  = out_res_r.reply_code;

endmodule
